// ===== hw/rtl/tti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_pkg: shared types and constants for the time table interpolator
// Table geometry, item formats, result codes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tti_pkg;

    // Table geometry
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths
    localparam int STAMP_W = 32;
    localparam int VALUE_W = 32;

    // Product of a 33-bit magnitude and a 32-bit time delta
    localparam int PROD_W    = VALUE_W + 1 + STAMP_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Interpolation sum: value plus a quotient clamped to 2^34
    localparam int QUO_W = 35;
    localparam int SUM_W = 36;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_HOLD   = 2'd2,
        OP_INTERP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef struct packed {
        t_op                        op;
        logic        [STAMP_W-1:0]  stamp;
        logic signed [VALUE_W-1:0]  sample;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        t_status                    status;
    } t_out_item;

    // Source of the result loaded into the result register
    typedef enum logic [2:0] {
        RES_NONE   = 3'd0,
        RES_EMPTY  = 3'd1,
        RES_FULL   = 3'd2,
        RES_HOLD   = 3'd3,
        RES_INTERP = 3'd4
    } t_res_sel;

    typedef struct packed {
        logic     latch;
        logic     clear;
        logic     append;
        logic     rd_first;
        logic     scan_start;
        logic     scan;
        logic     fetch0;
        logic     fetch1;
        logic     fetch2;
        logic     mul;
        logic     add;
        logic     div_step;
        logic     set_res;
        t_res_sel res_sel;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic op_append;
        logic op_clear;
        logic op_interp;
        logic count_zero;
        logic count_one;
        logic full;
        logic below;
        logic scan_go;
        logic tail;
        logic ds_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/tti_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tti_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_datapath: table storage, search index and interpolation arithmetic
// Holds the stamp and value RAMs, the entry count, the scan index, a
// 32x32 multiplier with a carry-in partial product, a restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module tti_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tti_pkg::t_in_item   i_item,
    input  tti_pkg::t_dp_cmd    i_cmd,
    output tti_pkg::t_dp_status o_status,
    output logic                o_valid,
    output tti_pkg::t_out_item  o_result,
    input  logic                i_stall
);

    import tti_pkg::*;

    // Latched item
    t_op                       r_op;
    logic        [STAMP_W-1:0] r_q;
    logic signed [VALUE_W-1:0] r_smp;

    // Table state and scan index
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   w_k_inc;
    logic [CNT_W-1:0]   w_k_dec;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_re;
    logic [STAMP_W-1:0] w_s_rd;
    logic [VALUE_W-1:0] w_v_rd;
    logic               w_above;

    // Interpolation operands
    logic [STAMP_W-1:0]        r_s0;
    logic signed [VALUE_W-1:0] r_v0;
    logic [VALUE_W:0]          r_mag;
    logic                      r_neg;
    logic [STAMP_W-1:0]        r_dt;
    logic [STAMP_W-1:0]        r_ds;
    logic signed [VALUE_W:0]   w_diff;

    // Multiply and divide
    logic [2*STAMP_W-1:0] w_pp;
    logic [PROD_W-1:0]    r_prod;
    logic [STAMP_W-1:0]   r_rem;
    logic [STAMP_W:0]     w_trial;
    logic                 w_ge;
    logic [STAMP_W:0]     w_rem_sub;
    logic [DIV_CNT_W-1:0] r_dcnt;

    // Result formation
    logic                    w_quo_big;
    logic [QUO_W-1:0]        w_quo;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_ovf_hi;
    logic                    w_ovf_lo;
    logic signed [VALUE_W-1:0] w_ival;
    logic signed [VALUE_W-1:0] r_val;
    t_status                 r_sts;
    logic                    r_ovalid;
    t_out_item               r_out;

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_item.op;
            r_q   <= i_item.stamp;
            r_smp <= i_item.sample;
        end
    end

    // Track the number of entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign w_k_inc = r_k + CNT_W'(1);
    assign w_k_dec = r_k - CNT_W'(1);

    // Select the read address for the current step
    always_comb begin
        w_re    = 1'b1;
        w_raddr = '0;
        if (i_cmd.rd_first) begin
            w_raddr = '0;
        end else if (i_cmd.scan_start) begin
            w_raddr = ADDR_W'(1);
        end else if (i_cmd.scan) begin
            w_raddr = w_k_inc[ADDR_W-1:0];
        end else if (i_cmd.fetch0) begin
            w_raddr = w_k_dec[ADDR_W-1:0];
        end else if (i_cmd.fetch1) begin
            w_raddr = r_k[ADDR_W-1:0];
        end else begin
            w_re = 1'b0;
        end
    end

    tti_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_q),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_s_rd)
    );

    tti_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_smp),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_v_rd)
    );

    assign w_above = r_q > w_s_rd;

    // Advance the scan index past every stamp below the query
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_k <= CNT_W'(1);
        end else if (i_cmd.scan) begin
            r_k <= r_k + CNT_W'(w_above);
        end
    end

    // Capture the lower entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch1) begin
            r_s0 <= w_s_rd;
            r_v0 <= w_v_rd;
        end
    end

    // Form magnitude and deltas from the upper entry
    assign w_diff = {w_v_rd[VALUE_W-1], w_v_rd} - {r_v0[VALUE_W-1], r_v0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch2) begin
            r_neg <= w_diff[VALUE_W];
            r_mag <= w_diff[VALUE_W] ? -w_diff : w_diff;
            r_dt  <= r_q - r_s0;
            r_ds  <= w_s_rd - r_s0;
        end
    end

    // Multiply, then divide in place one quotient bit per cycle
    assign w_pp      = r_mag[VALUE_W-1:0] * r_dt;
    assign w_trial   = {r_rem, r_prod[PROD_W-1]};
    assign w_ge      = w_trial >= {1'b0, r_ds};
    assign w_rem_sub = w_trial - {1'b0, r_ds};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= {1'b0, w_pp};
        end else if (i_cmd.add) begin
            r_prod <= r_prod + (r_mag[VALUE_W] ? {1'b0, r_dt, {STAMP_W{1'b0}}}
                                               : {PROD_W{1'b0}});
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[PROD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_rem_sub[STAMP_W-1:0] : w_trial[STAMP_W-1:0];
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
        end
    end

    // Clamp the quotient to 2^34, add and saturate
    assign w_quo_big = (|r_prod[PROD_W-1:QUO_W])
                    || (r_prod[QUO_W-1] && (|r_prod[QUO_W-2:0]));
    assign w_quo     = w_quo_big ? {1'b1, {(QUO_W-1){1'b0}}} : r_prod[QUO_W-1:0];
    assign w_sum     = r_neg ? {{(SUM_W-VALUE_W){r_v0[VALUE_W-1]}}, r_v0}
                               - {1'b0, w_quo}
                             : {{(SUM_W-VALUE_W){r_v0[VALUE_W-1]}}, r_v0}
                               + {1'b0, w_quo};
    assign w_ovf_hi  = !w_sum[SUM_W-1] && (|w_sum[SUM_W-2:VALUE_W-1]);
    assign w_ovf_lo  = w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:VALUE_W-1]);

    always_comb begin
        if (w_ovf_hi) begin
            w_ival = {1'b0, {(VALUE_W-1){1'b1}}};
        end else if (w_ovf_lo) begin
            w_ival = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            w_ival = w_sum[VALUE_W-1:0];
        end
    end

    // Set the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            case (i_cmd.res_sel)
                RES_EMPTY: begin
                    r_val <= '0;
                    r_sts <= ST_EMPTY;
                end
                RES_FULL: begin
                    r_val <= '0;
                    r_sts <= ST_FULL;
                end
                RES_HOLD: begin
                    r_val <= r_v0;
                    r_sts <= ST_OK;
                end
                RES_INTERP: begin
                    r_val <= w_ival;
                    r_sts <= (w_ovf_hi || w_ovf_lo) ? ST_SAT : ST_OK;
                end
                default: begin
                    r_val <= '0;
                    r_sts <= ST_OK;
                end
            endcase
        end
    end

    // Output register: hold the beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.value  <= r_val;
            r_out.status <= r_sts;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    // Status to the controller
    assign o_status.op_append  = r_op == OP_APPEND;
    assign o_status.op_clear   = r_op == OP_CLEAR;
    assign o_status.op_interp  = r_op == OP_INTERP;
    assign o_status.count_zero = r_count == '0;
    assign o_status.count_one  = r_count == CNT_W'(1);
    assign o_status.full       = r_count == CNT_W'(DEPTH);
    assign o_status.below      = r_q < w_s_rd;
    assign o_status.scan_go    = w_above && (w_k_inc < r_count);
    assign o_status.tail       = r_k >= r_count;
    assign o_status.ds_zero    = r_ds == '0;
    assign o_status.div_last   = r_dcnt == DIV_CNT_W'(DIV_STEPS - 1);
    assign o_status.out_free   = !r_ovalid || !i_stall;

endmodule

// ===== hw/rtl/tti_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_ctrl: sequencer for the time table interpolator
// Walks one item through decode, linear scan, entry fetch, multiply,
// divide and result hand-off to the output register.
// ----------------------------------------------------------------------------
module tti_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tti_pkg::t_dp_status i_status,
    output tti_pkg::t_dp_cmd    o_cmd
);

    import tti_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_FIRST  = 12'b0000_0000_0100,
        S_SCAN   = 12'b0000_0000_1000,
        S_FETCH0 = 12'b0000_0001_0000,
        S_FETCH1 = 12'b0000_0010_0000,
        S_FETCH2 = 12'b0000_0100_0000,
        S_MUL    = 12'b0000_1000_0000,
        S_ADD    = 12'b0001_0000_0000,
        S_DIV    = 12'b0010_0000_0000,
        S_FINISH = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op_clear) begin
                    o_cmd.clear   = 1'b1;
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_NONE;
                    n_state       = S_DONE;
                end else if (i_status.op_append) begin
                    o_cmd.set_res = 1'b1;
                    if (i_status.full) begin
                        o_cmd.res_sel = RES_FULL;
                    end else begin
                        o_cmd.append  = 1'b1;
                        o_cmd.res_sel = RES_NONE;
                    end
                    n_state = S_DONE;
                end else if (i_status.count_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_EMPTY;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_status.below) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_EMPTY;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = i_status.count_one ? S_FETCH0 : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (!i_status.scan_go) begin
                    n_state = S_FETCH0;
                end
            end
            S_FETCH0: begin
                o_cmd.fetch0 = 1'b1;
                n_state      = S_FETCH1;
            end
            S_FETCH1: begin
                o_cmd.fetch1 = 1'b1;
                n_state      = S_FETCH2;
            end
            S_FETCH2: begin
                o_cmd.fetch2 = 1'b1;
                if (!i_status.op_interp || i_status.tail) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_HOLD;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.ds_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RES_HOLD;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_sel = RES_INTERP;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/time_table_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_table_interpolator: stamp/value table with hold and linear lookup
// Input channel: i_valid / o_stall with one t_in_item per beat (clear,
// append, hold lookup, interpolating lookup). Output channel: o_valid /
// i_stall with one t_out_item per input beat, in order.
// Clear, append and an empty table are answered from decode; a query before
// the first entry after the first stamp is read. A lookup scans the table
// entry by entry and then fetches the two neighboring entries, and an
// interpolation adds multiply, add, 65-step divide and finish, which it
// skips when the two neighboring stamps are equal. The linear scan reads one
// stamp per cycle from the stamp RAM's single read port, and the divider
// retires one quotient bit per cycle.
// One item is in work at a time; o_stall is high while it is. A finished
// result sits in the output register, so the next item is accepted while
// the receiver stalls; the block then waits with its result ready.
// Reset empties the table (entry count zero) and drops any pending beat.
// ----------------------------------------------------------------------------
module time_table_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tti_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output tti_pkg::t_out_item o_result
);

    import tti_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    tti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_sts),
        .o_cmd    (w_cmd)
    );

    tti_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_sts),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

`ifndef SYNTHESIS
    // An accepted beat makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a beat");

    // Never write past the end of the table
    a_no_append_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.append |-> !w_sts.full)
        else $error("append issued on a full table");

    // At most one read address source per cycle
    a_one_read_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.rd_first, w_cmd.scan_start, w_cmd.scan,
                  w_cmd.fetch0, w_cmd.fetch1}))
        else $error("conflicting table read commands");

    // A loaded result shows up on the output next cycle
    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_valid)
        else $error("loaded result not presented");
`endif

endmodule

// ===== tb/tti_answer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_answer_checker: predicts and checks the lookup answers of the table
// Watches both channels of the time table interpolator. Keeps a private
// copy of the stamp/value table and works out the answer for every beat
// taken on the input side. Every beat on the output side is compared,
// field by field, with the oldest answer still outstanding.
// ----------------------------------------------------------------------------
module tti_answer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tti_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tti_pkg::t_out_item i_out_result,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tti_pkg::*;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    // Private copy of the table
    logic        [STAMP_W-1:0] stamp_mem [DEPTH];
    logic signed [VALUE_W-1:0] value_mem [DEPTH];
    int unsigned               entry_cnt;

    // Answers owed by the block, oldest first
    t_out_item answer_q [$];

    // Apply one command to the table copy and return the answer it gives
    function automatic t_out_item answer_for(input t_in_item cmd);
        t_out_item   res;
        int unsigned slot;
        longint      v0;
        longint      v1;
        longint      diff;
        longint      total;
        logic [31:0] dt;
        logic [31:0] ds;
        logic [63:0] mag;
        logic [63:0] quo;
        bit          neg;
        res.value  = '0;
        res.status = ST_OK;
        case (cmd.op)
            OP_CLEAR: begin
                entry_cnt = 0;
            end
            OP_APPEND: begin
                if (entry_cnt < DEPTH) begin
                    stamp_mem[entry_cnt] = cmd.stamp;
                    value_mem[entry_cnt] = cmd.sample;
                    entry_cnt++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            default: begin
                if (entry_cnt == 0 || cmd.stamp < stamp_mem[0]) begin
                    res.status = ST_EMPTY;
                end else begin
                    // first entry from 1 up whose stamp is not below the query
                    slot = 1;
                    while (slot < entry_cnt && cmd.stamp > stamp_mem[slot])
                        slot++;
                    if (cmd.op == OP_HOLD) begin
                        res.value = value_mem[slot-1];
                    end else if (slot >= entry_cnt) begin
                        res.value = value_mem[entry_cnt-1];
                    end else begin
                        v0    = value_mem[slot-1];
                        v1    = value_mem[slot];
                        dt    = cmd.stamp - stamp_mem[slot-1];
                        ds    = stamp_mem[slot] - stamp_mem[slot-1];
                        total = v0;
                        if (ds != 0) begin
                            // scale the magnitude, truncate toward zero, clamp
                            diff = v1 - v0;
                            neg  = diff < 0;
                            mag  = neg ? -diff : diff;
                            quo  = (mag * {32'd0, dt}) / {32'd0, ds};
                            if (quo > (64'd1 << 34))
                                quo = 64'd1 << 34;
                            total = neg ? v0 - $signed(quo) : v0 + $signed(quo);
                            if (total > VAL_MAX) begin
                                total      = VAL_MAX;
                                res.status = ST_SAT;
                            end else if (total < VAL_MIN) begin
                                total      = VAL_MIN;
                                res.status = ST_SAT;
                            end
                        end
                        res.value = total[31:0];
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Check the output beat first, then queue the answer for the input beat
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            entry_cnt    = 0;
            answer_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: result beat with no answer owed: value %h code %0d",
                             $time, i_out_result.value, i_out_result.status);
                    o_fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_out_result.value !== want.value) begin
                        $display("%0t: value mismatch: expected %h, actual %h",
                                 $time, want.value, i_out_result.value);
                        o_fail_count++;
                    end
                    if (i_out_result.status !== want.status) begin
                        $display("%0t: result code mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_out_result.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                answer_q.push_back(answer_for(i_in_item));
            o_pending = answer_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the time table interpolator
// Drives clear, append and lookup commands: a short directed opening, then
// table-building sessions with random stamps and samples followed by hold
// and interpolating queries aimed at the stored stamps, one table filled to
// capacity, and some unsorted and random noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import tti_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int LIMIT_CYCLES = 8_000_000;
    localparam int MAX_GAP      = 14;
    localparam int DRAIN_CYCLES = 200;

    // Ways to pick stamps while building a table
    localparam int FILL_MIXED     = 0;
    localparam int FILL_SCRAMBLED = 1;
    localparam int FILL_DENSE     = 2;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_result;
    int        fail_count;
    int        pending;

    int          items_sent = 0;
    int          send_calm  = 0;
    int          recv_calm  = 0;
    logic [31:0] stamp_list [$];

    always #1 clk = ~clk;

    time_table_interpolator DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (in_valid),
        .o_stall  (in_stall),
        .i_item   (in_item),
        .o_valid  (out_valid),
        .i_stall  (out_stall),
        .o_result (out_result)
    );

    tti_answer_checker u_answers (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_result (out_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle cycles before a beat; now and then a run with no idling at all
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Present one command beat and hold it until the block takes it
    task automatic send_beat(input t_op op, input logic [31:0] stamp,
                             input logic [31:0] sample);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  = '{op, stamp, sample};
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
        // track stored stamps so that queries can aim at them
        if (op == OP_CLEAR)
            stamp_list.delete();
        else if (op == OP_APPEND && stamp_list.size() < DEPTH)
            stamp_list.push_back(stamp);
    endtask

    // Query stamp on, beside, before or after the stored entries
    function automatic logic [31:0] pick_query_stamp();
        int idx;
        if (stamp_list.size() == 0)
            return $urandom;
        idx = $urandom_range(0, stamp_list.size() - 1);
        case ($urandom_range(0, 5))
            0:       return stamp_list[idx];
            1:       return stamp_list[0] - $urandom_range(1, 50);
            2:       return stamp_list[idx] + $urandom_range(1, 500);
            3:       return stamp_list[stamp_list.size() - 1] + $urandom_range(1, 1000);
            4:       return stamp_list[idx] - 1;
            default: return $urandom;
        endcase
    endfunction

    // Append a run of entries
    task automatic fill_table(input int count, input int style);
        logic [31:0] stamp;
        stamp = (style == FILL_DENSE) ? $urandom_range(0, 1 << 20) : $urandom;
        repeat (count) begin
            send_beat(OP_APPEND, stamp, $urandom);
            if (style == FILL_SCRAMBLED) begin
                stamp = $urandom;
            end else if (style == FILL_DENSE) begin
                stamp += $urandom_range(0, 4096);
            end else begin
                // equal neighbors, short, wide and wrapping steps
                case ($urandom_range(0, 7))
                    0:       stamp = stamp;
                    6:       stamp += $urandom_range(1, 1 << 20);
                    7:       stamp += $urandom;
                    default: stamp += $urandom_range(1, 1000);
                endcase
            end
        end
    endtask

    // Issue a run of hold and interpolating lookups
    task automatic query_burst(input int count);
        repeat (count)
            send_beat(($urandom_range(0, 2) == 0) ? OP_HOLD : OP_INTERP,
                      pick_query_stamp(), $urandom);
    endtask

    // Accept results, stalling a random number of cycles before each one
    initial begin : result_sink
        int k;
        wait (rst_n);
        @(negedge clk);
        forever begin
            k = draw_gap(recv_calm);
            if (k > 0) begin
                out_stall = 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Bound the run
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int  full_at;
        bit  full_done;
        full_done = 1'b0;
        full_at   = $urandom_range(0, 600);
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty table after reset
        send_beat(OP_HOLD,   32'h0000_0000, 32'h0000_0000);
        send_beat(OP_INTERP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // single entry: before, on and past it
        send_beat(OP_APPEND, 32'd100,       32'h7FFF_FFFF);
        send_beat(OP_HOLD,   32'd99,        32'h0000_0000);
        send_beat(OP_INTERP, 32'd100,       32'h0000_0000);
        send_beat(OP_INTERP, 32'hFFFF_FFFF, 32'h0000_0000);
        // equal neighboring stamps
        send_beat(OP_APPEND, 32'd100,       32'h8000_0000);
        send_beat(OP_INTERP, 32'd100,       32'h0000_0000);
        // midpoint from the most negative value
        send_beat(OP_APPEND, 32'd300,       32'h0000_0000);
        send_beat(OP_INTERP, 32'd200,       32'h0000_0000);
        send_beat(OP_HOLD,   32'd250,       32'h0000_0000);
        // top stamp, then just below and on it
        send_beat(OP_APPEND, 32'hFFFF_FFFF, 32'h1234_5678);
        send_beat(OP_INTERP, 32'hFFFF_FFFE, 32'h0000_0000);
        send_beat(OP_INTERP, 32'hFFFF_FFFF, 32'h0000_0000);
        // out-of-order append, early query
        send_beat(OP_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(OP_INTERP, 32'd5,         32'h0000_0000);
        send_beat(OP_HOLD,   32'd400,       32'h0000_0000);
        // clear, then query the empty table
        send_beat(OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
        send_beat(OP_INTERP, 32'd100,       32'h0000_0000);
        // rebuild from stamp zero with a steep rise
        send_beat(OP_APPEND, 32'h0000_0000, 32'h0000_0000);
        send_beat(OP_HOLD,   32'h0000_0000, 32'h0000_0000);
        send_beat(OP_APPEND, 32'd10,        32'h7FFF_FFFF);
        send_beat(OP_INTERP, 32'd3,         32'h0000_0000);
        send_beat(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // random sessions
        while (items_sent < ITEM_TARGET) begin
            if (!full_done && items_sent >= full_at) begin
                // fill to capacity, refuse a few more, look up in the full table
                send_beat(OP_CLEAR, $urandom, $urandom);
                fill_table(DEPTH, FILL_DENSE);
                fill_table(3, FILL_MIXED);
                query_burst(8);
                full_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        repeat ($urandom_range(3, 8))
                            send_beat(t_op'($urandom_range(0, 3)), $urandom, $urandom);
                    end
                    1: begin
                        send_beat(OP_CLEAR, $urandom, $urandom);
                        fill_table($urandom_range(1, 16), FILL_SCRAMBLED);
                        query_burst($urandom_range(3, 10));
                    end
                    default: begin
                        if ($urandom_range(0, 4) != 0)
                            send_beat(OP_CLEAR, $urandom, $urandom);
                        case ($urandom_range(0, 5))
                            0:       fill_table(1, FILL_MIXED);
                            1:       fill_table(2, FILL_MIXED);
                            default: fill_table($urandom_range(0, 24), FILL_MIXED);
                        endcase
                        query_burst($urandom_range(3, 14));
                    end
                endcase
            end
        end

        // drain, then watch for stray results
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
